>>> rtl/ile_pkg.sv
package ile_pkg;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int CNT_W  = 5;
   localparam int DATA_W = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE_LAST  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT_AT    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE_AT    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ_AT      = 3'd5;

   // what every cell does with its value
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_READ
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [DATA_W-1:0]  value;
   } cell_ctl_type;

endpackage

>>> rtl/ile_cell.sv
module ile_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic                              clock,
   input  ile_pkg::cell_ctl_type             ctl,
   input  logic [IDX_W-1:0]                  pos,
   input  logic signed [ile_pkg::DATA_W-1:0] left_value,
   input  logic signed [ile_pkg::DATA_W-1:0] right_value,
   input  logic signed [ile_pkg::DATA_W-1:0] rd_in,
   output logic signed [ile_pkg::DATA_W-1:0] value,
   output logic signed [ile_pkg::DATA_W-1:0] rd_out
);

   localparam logic [IDX_W-1:0] HERE = IDX_W'(INDEX);

   logic signed [ile_pkg::DATA_W-1:0] value_ff;
   logic signed [ile_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         ile_pkg::CELL_INSERT: begin
            if (HERE == pos) begin
               value_in = ctl.value;
            end else if (HERE > pos) begin
               value_in = left_value;
            end
         end
         ile_pkg::CELL_REMOVE: begin
            if (HERE >= pos) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

   // read tap joins the or chain running along the row
   assign rd_out = rd_in | (((ctl.op == ile_pkg::CELL_READ) && (HERE == pos)) ?
                            value_ff : '0);

endmodule

>>> rtl/ile_ctrl.sv
module ile_ctrl #(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4,
   parameter int OCC_W    = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic [ile_pkg::CMD_W-1:0]         cmd,
   input  logic [ile_pkg::POS_W-1:0]         position,
   input  logic signed [ile_pkg::DATA_W-1:0] item_value,
   output ile_pkg::cell_ctl_type             ctl,
   output logic [IDX_W-1:0]                  cell_pos,
   output logic                              ok,
   output logic [OCC_W-1:0]                  count_next,
   output logic [OCC_W-1:0]                  count
);

   localparam int CMP_W = (OCC_W > ile_pkg::POS_W) ? OCC_W : ile_pkg::POS_W;

   logic [OCC_W-1:0]     count_ff;
   logic [OCC_W-1:0]     count_in;
   logic [CMP_W-1:0]     pos_ext;
   logic [CMP_W-1:0]     count_ext;
   logic [CMP_W-1:0]     idx;
   logic                 full;
   logic                 empty;
   ile_pkg::cell_op_type op;

   assign pos_ext   = CMP_W'(position);
   assign count_ext = CMP_W'(count_ff);
   assign full      = (count_ff == OCC_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      ok         = 1'b0;
      op         = ile_pkg::CELL_HOLD;
      idx        = pos_ext;
      count_next = count_ff;
      case (cmd)
         ile_pkg::CMD_APPEND: begin
            if (!full) begin
               ok         = 1'b1;
               op         = ile_pkg::CELL_INSERT;
               idx        = count_ext;
               count_next = count_ff + OCC_W'(1);
            end
         end
         ile_pkg::CMD_REMOVE_FIRST: begin
            if (!empty) begin
               ok         = 1'b1;
               op         = ile_pkg::CELL_REMOVE;
               idx        = '0;
               count_next = count_ff - OCC_W'(1);
            end
         end
         ile_pkg::CMD_REMOVE_LAST: begin
            if (!empty) begin
               ok         = 1'b1;
               op         = ile_pkg::CELL_REMOVE;
               idx        = count_ext - CMP_W'(1);
               count_next = count_ff - OCC_W'(1);
            end
         end
         ile_pkg::CMD_INSERT_AT: begin
            if ((pos_ext <= count_ext) && !full) begin
               ok         = 1'b1;
               op         = ile_pkg::CELL_INSERT;
               count_next = count_ff + OCC_W'(1);
            end
         end
         ile_pkg::CMD_REMOVE_AT: begin
            if (pos_ext < count_ext) begin
               ok         = 1'b1;
               op         = ile_pkg::CELL_REMOVE;
               count_next = count_ff - OCC_W'(1);
            end
         end
         ile_pkg::CMD_READ_AT: begin
            if (pos_ext < count_ext) begin
               ok = 1'b1;
               op = ile_pkg::CELL_READ;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign ctl.op    = fire ? op : ile_pkg::CELL_HOLD;
   assign ctl.value = item_value;
   assign cell_pos  = idx[IDX_W-1:0];
   assign count_in  = fire ? count_next : count_ff;
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/indexed_list_engine_top.sv
// indexed list engine: an ordered list of up to CAPACITY signed 32-bit entries
// kept in a row of cells, entry i in cell i. each request appends, removes the
// first or last entry, inserts at an index (index equal to the count appends),
// removes at an index, or reads at an index; every request gives one response
// with a success flag, the entry count after the request and the value read
// (zero unless a read succeeds). out-of-range indices, a full list and removal
// from an empty list are refused and leave the list unchanged, as do the
// unused command codes 6 and 7. all cells shift toward or away from the index
// in parallel in the cycle a request is accepted, and its response is
// registered along with the new cell values. a new request is taken in every
// cycle in which the response register is empty or being drained, so the
// sustained rate is one request per cycle. there is no clearing pass; cells
// at or above the count are never read.
module indexed_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[4:0], item_value[36:5], zero pad
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // entry_count[4:0], read_value[36:5], zero pad
   output logic        rsp_tuser    // ok
);

   // index width addresses every cell, count width holds CAPACITY itself
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int DW    = ile_pkg::DATA_W;

   // response register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_ok_ff;
   logic [ile_pkg::CNT_W-1:0] rsp_count_ff;
   logic signed [DW-1:0]      rsp_value_ff;

   // request unpacking
   logic [ile_pkg::POS_W-1:0] position;
   logic signed [DW-1:0]      item_value;
   logic                      fire;

   assign position   = req_tdata[ile_pkg::POS_W-1:0];
   assign item_value = req_tdata[ile_pkg::POS_W +: DW];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   // decode and occupancy count
   ile_pkg::cell_ctl_type ctl;
   logic [IDX_W-1:0]      cell_pos;
   logic                  ok;
   logic [OCC_W-1:0]      count_next;
   logic [OCC_W-1:0]      count;

   ile_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .OCC_W    (OCC_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .cmd        (req_tuser),
      .position   (position),
      .item_value (item_value),
      .ctl        (ctl),
      .cell_pos   (cell_pos),
      .ok         (ok),
      .count_next (count_next),
      .count      (count)
   );

   // row of cells; values pass to both neighbors, read data rides an or chain
   logic signed [DW-1:0] cell_value [CAPACITY];
   logic signed [DW-1:0] rd_chain   [CAPACITY+1];

   assign rd_chain[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DW-1:0] left_value;
      logic signed [DW-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end

      ile_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pos         (cell_pos),
         .left_value  (left_value),
         .right_value (right_value),
         .rd_in       (rd_chain[i]),
         .value       (cell_value[i]),
         .rd_out      (rd_chain[i+1])
      );
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ok_ff    <= ok;
         rsp_count_ff <= ile_pkg::CNT_W'(count_next);
         rsp_value_ff <= rd_chain[CAPACITY];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {3'b000, rsp_value_ff, rsp_count_ff};

   // the count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= OCC_W'(CAPACITY))
      else $error("entry count above capacity");

   // a refused request leaves the count alone
   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      fire && !ok |=> count == $past(count))
      else $error("refused request changed the count");

   // a response that is not a successful read carries zero data
   a_zero_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (!rsp_ok_ff || $past(req_tuser) != ile_pkg::CMD_READ_AT)
      && $past(fire) |-> rsp_value_ff == '0)
      else $error("nonzero read value on non-read response");

   // the count moves by at most one per request and only when one is taken
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !fire |=> count == $past(count))
      else $error("count changed without a request");

   // an accepted request always yields a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

endmodule

>>> tb/indexed_list_engine_top_tb.sv
module indexed_list_engine_top_tb;

   import ile_pkg::*;

   localparam int CAPACITY       = 16;
   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int PHASE_LEN      = 50;
   localparam int MAX_IDLE       = 17;
   localparam int DRAIN_CYCLES   = 20;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int MAX_PRINTED    = 30;
   // long receiver hold-offs, counted from reset release
   localparam int HOLD1_START    = 2000;
   localparam int HOLD1_LEN      = 400;
   localparam int HOLD2_START    = 7000;
   localparam int HOLD2_LEN      = 300;

   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] VAL_ONES = -32'sd1;
   localparam logic signed [DATA_W-1:0] VAL_ZERO = 32'sd0;

   // random phases: fill the list, drain it, or mix
   typedef enum int {
      PH_GROW,
      PH_SHRINK,
      PH_MIX
   } list_phase_t;

   typedef struct {
      logic [CMD_W-1:0]         cmd;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      int unsigned              gap;      // idle cycles before this request
   } list_request_t;

   typedef struct {
      logic                     ok;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] value;
   } list_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // position[4:0], item_value[36:5], zero pad
   logic [2:0]  req_tuser = '0;   // cmd[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // entry_count[4:0], read_value[36:5], zero pad
   logic        rsp_tuser;        // ok

   // requests waiting to be driven, results waiting to be seen
   list_request_t pending_requests[$];
   list_result_t  pending_results[$];

   // predicted list contents
   logic signed [DATA_W-1:0] list_cells[CAPACITY];
   int                       list_count = 0;

   int          err_count = 0;
   int          gen_count = 0;    // list length as the request generator sees it
   bit          send_calm = 1'b0;
   bit          rsp_calm  = 1'b0;
   int unsigned rsp_wait  = 0;
   logic        rsp_hold  = 1'b0;
   int          run_cycles = 0;

   indexed_list_engine_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // apply one request to the predicted list and return its response
   function automatic list_result_t list_apply(logic [CMD_W-1:0] op, logic [POS_W-1:0] idx,
                                               logic signed [DATA_W-1:0] v);
      list_result_t r;
      int           at;
      int           i;
      r = '{ok: 1'b0, count: '0, value: '0};
      case (op)
         CMD_APPEND, CMD_INSERT_AT: begin
            at = (op == CMD_APPEND) ? list_count : int'(idx);
            // index equal to the count appends; full list refuses
            if (list_count < CAPACITY && at <= list_count) begin
               for (i = list_count; i > at; i--)
                  list_cells[i] = list_cells[i-1];
               list_cells[at] = v;
               list_count++;
               r.ok = 1'b1;
            end
         end
         CMD_REMOVE_FIRST, CMD_REMOVE_LAST, CMD_REMOVE_AT: begin
            at = (op == CMD_REMOVE_FIRST) ? 0 :
                 (op == CMD_REMOVE_LAST)  ? list_count - 1 : int'(idx);
            if (list_count > 0 && at < list_count) begin
               for (i = at; i + 1 < list_count; i++)
                  list_cells[i] = list_cells[i+1];
               list_count--;
               r.ok = 1'b1;
            end
         end
         CMD_READ_AT: begin
            if (int'(idx) < list_count) begin
               r.value = list_cells[idx];
               r.ok    = 1'b1;
            end
         end
         default: begin
            // spare codes are refused, nothing changes
         end
      endcase
      r.count = list_count[CNT_W-1:0];
      return r;
   endfunction

   // list length after a request, used only to steer positions
   function automatic int count_after(logic [CMD_W-1:0] op, logic [POS_W-1:0] idx, int n);
      case (op)
         CMD_APPEND:                       return (n < CAPACITY) ? n + 1 : n;
         CMD_INSERT_AT:                    return (n < CAPACITY && idx <= n) ? n + 1 : n;
         CMD_REMOVE_FIRST, CMD_REMOVE_LAST: return (n > 0) ? n - 1 : n;
         CMD_REMOVE_AT:                    return (idx < n) ? n - 1 : n;
         default:                          return n;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= MAX_PRINTED)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // queue one request with its idle gap
   task automatic add_request(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] idx,
                              input logic signed [DATA_W-1:0] v);
      list_request_t rq;
      if ($urandom_range(0, 39) == 0)
         send_calm = !send_calm;
      rq.cmd   = op;
      rq.pos   = idx;
      rq.value = v;
      rq.gap   = (send_calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
      pending_requests.push_back(rq);
      gen_count = count_after(op, idx, gen_count);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 31))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return VAL_ONES;
         3:       return VAL_ZERO;
         default: return $urandom;
      endcase
   endfunction

   // stimulus: directed corners first, then phased random traffic
   initial begin
      list_phase_t      phase;
      int               add_pct;
      int               i;
      logic [CMD_W-1:0] op;
      logic [POS_W-1:0] idx;

      phase = PH_MIX;

      // empty list: every remove and read is refused
      add_request(CMD_READ_AT,      5'd0,  VAL_ZERO);
      add_request(CMD_REMOVE_FIRST, 5'd0,  VAL_ZERO);
      add_request(CMD_REMOVE_LAST,  5'd0,  VAL_ZERO);
      add_request(CMD_REMOVE_AT,    5'd0,  VAL_ZERO);
      add_request(CMD_INSERT_AT,    5'd1,  VAL_MAX);    // index above count
      // spare command codes
      add_request(CMD_SPARE_6,      5'd0,  VAL_ZERO);
      add_request(CMD_SPARE_7,      5'd31, VAL_ONES);
      // build a list with the extreme values
      add_request(CMD_INSERT_AT,    5'd0,  VAL_MIN);
      add_request(CMD_APPEND,       5'd0,  VAL_MAX);
      add_request(CMD_APPEND,       5'd31, VAL_ONES);
      add_request(CMD_INSERT_AT,    5'd1,  VAL_ZERO);
      add_request(CMD_INSERT_AT,    5'd4,  32'sh1234_5678); // index equal to count
      add_request(CMD_INSERT_AT,    5'd6,  VAL_ONES);       // index above count
      add_request(CMD_READ_AT,      5'd0,  VAL_ZERO);
      add_request(CMD_READ_AT,      5'd4,  VAL_ZERO);
      add_request(CMD_READ_AT,      5'd5,  VAL_ZERO);       // index at count
      add_request(CMD_REMOVE_AT,    5'd1,  VAL_ZERO);
      add_request(CMD_REMOVE_AT,    5'd31, VAL_ZERO);
      add_request(CMD_REMOVE_FIRST, 5'd0,  VAL_ZERO);
      add_request(CMD_REMOVE_LAST,  5'd0,  VAL_ZERO);
      add_request(CMD_READ_AT,      5'd1,  VAL_ZERO);
      add_request(CMD_READ_AT,      5'd16, VAL_ZERO);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_LEN == 0)
            phase = list_phase_t'($urandom_range(0, 2));
         add_pct = (phase == PH_GROW) ? 75 : (phase == PH_SHRINK) ? 20 : 45;
         if ($urandom_range(0, 99) < 4) begin
            // noise: spare codes with arbitrary fields
            op = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
         end else if ($urandom_range(0, 99) < add_pct) begin
            op = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT_AT;
         end else begin
            case ($urandom_range(0, 3))
               0:       op = CMD_REMOVE_FIRST;
               1:       op = CMD_REMOVE_LAST;
               2:       op = CMD_REMOVE_AT;
               default: op = CMD_READ_AT;
            endcase
         end
         // mostly in-range positions, some anywhere in the field
         if ($urandom_range(0, 9) == 0)
            idx = $urandom_range(0, 31);
         else if (op == CMD_INSERT_AT || op == CMD_APPEND)
            idx = $urandom_range(0, gen_count);
         else if (gen_count > 0)
            idx = $urandom_range(0, gen_count - 1);
         else
            idx = '0;
         add_request(op, idx, pick_value());
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // wait for every request to go in and every response to come back
      while (pending_requests.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("indexed_list_engine_top_tb OK");
      else
         $display("indexed_list_engine_top_tb NOT OK");
      $finish;
   end

   // request driver: predict on every accepted request, then offer the next
   always @(posedge clock) begin
      list_request_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            pending_results.push_back(list_apply(req_tuser, req_tdata[4:0], req_tdata[36:5]));
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_requests[0].gap > 0) begin
               // idle gap before the next request
               pending_requests[0].gap = pending_requests[0].gap - 1;
               req_tvalid <= 1'b0;
            end else begin
               nxt = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, nxt.value, nxt.pos};
               req_tuser  <= nxt.cmd;
            end
         end
      end
   end

   // long hold-offs on the response side so the block fills and stalls requests
   always @(posedge clock) begin
      if (reset) begin
         run_cycles <= 0;
         rsp_hold   <= 1'b0;
      end else begin
         run_cycles <= run_cycles + 1;
         rsp_hold   <= (run_cycles >= HOLD1_START && run_cycles < HOLD1_START + HOLD1_LEN) ||
                       (run_cycles >= HOLD2_START && run_cycles < HOLD2_START + HOLD2_LEN);
      end
   end

   // response monitor: compare against the oldest prediction, stall at random
   always @(posedge clock) begin
      list_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.ok)
                  report_mismatch($sformatf("ok %b, expected %b", rsp_tuser, want.ok));
               if (rsp_tdata[4:0] !== want.count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_tdata[4:0], want.count));
               if (rsp_tdata[36:5] !== want.value)
                  report_mismatch($sformatf("read_value %h, expected %h",
                                            rsp_tdata[36:5], want.value));
            end
            if ($urandom_range(0, 39) == 0)
               rsp_calm = !rsp_calm;
            rsp_wait = (rsp_calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0) && !rsp_hold;
      end
   end

   // watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("indexed_list_engine_top_tb NOT OK");
      $finish;
   end

endmodule

>>> files.f
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/ile_ctrl.sv
rtl/indexed_list_engine_top.sv
tb/indexed_list_engine_top_tb.sv
